// ----- design/qsu_pkg.sv -----
package qsu_pkg;

    // Width of the collected code point
    localparam int CP_W = 24;

    // Result kinds, carried on tuser
    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_ERR  = 2'd2
    } t_kind;

    // Error codes
    localparam logic [1:0] E_NO_QUOTE = 2'd0;
    localparam logic [1:0] E_BAD_ESC  = 2'd1;
    localparam logic [1:0] E_UNTERM   = 2'd2;
    localparam logic [1:0] E_BAD_CP   = 2'd3;

    // One queued command: up to four UTF-8 bytes, then an optional tail result
    typedef struct packed {
        logic [2:0]      cp_len;
        logic [3:0][7:0] cp_bytes;
        logic            tail_vld;
        t_kind           tail_kind;
        logic [7:0]      tail_data;
        logic [1:0]      tail_err;
    } t_cmd;

    // One result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [1:0] err;
        logic       last;
    } t_res;

endpackage

// ----- design/quoted_string_unescape_utf8.sv -----
// Unescapes one double-quoted string per run from a byte stream. Send bytes on
// the slave side; results leave on the master side as content bytes
// (tuser 0), an end beat at the closing quote (tuser 1) or an error beat
// (tuser 2, code in tdata[9:8]), with tlast on the final beat that each
// input byte causes. Input is taken at one byte per cycle while the queue has
// room; a \u+ or \U+ escape expands into up to five result beats, which the
// back end sends one per cycle while the output is ready, so a run of such
// escapes holds the input off once the command queue of FIFO_DEPTH entries
// fills. A result reaches the output via the command queue and output register.
module quoted_string_unescape_utf8 #(
    parameter int MAX_HEX_DIGITS = 6,
    parameter int FIFO_DEPTH     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [9:8] error_code
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast
);

    qsu_pkg::t_cmd push_cmd, head_cmd;
    qsu_pkg::t_res res;
    logic          push, pop, full, head_vld;

    qsu_front #(
        .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_s_tvalid),
        .i_data (i_s_tdata),
        .i_full (full),
        .o_rdy  (o_s_tready),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    qsu_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_full (full),
        .o_vld  (head_vld),
        .o_cmd  (head_cmd)
    );

    qsu_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (head_vld),
        .i_cmd  (head_cmd),
        .o_pop  (pop),
        .o_vld  (o_m_tvalid),
        .i_rdy  (i_m_tready),
        .o_res  (res)
    );

    // Pack the result beat
    assign o_m_tdata = {6'd0, res.err, res.data};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule

// ----- design/qsu_front.sv -----
module qsu_front #(
    parameter int MAX_HEX_DIGITS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [7:0]    i_data,
    input  logic          i_full,
    output logic          o_rdy,
    output logic          o_push,
    output qsu_pkg::t_cmd o_cmd
);

    localparam int CW = $clog2(MAX_HEX_DIGITS + 1);

    typedef enum logic [2:0] {
        M_WAIT = 3'd0,
        M_BODY = 3'd1,
        M_ESC  = 3'd2,
        M_PLUS = 3'd3,
        M_HEX  = 3'd4
    } t_mode;

    typedef struct packed {
        logic           vld;
        qsu_pkg::t_kind kind;
        logic [7:0]     data;
        logic [1:0]     err;
        t_mode          mode;
    } t_body;

    // Hex digit value, bit 4 flags a digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic cp_ok(input logic [qsu_pkg::CP_W-1:0] cp);
        logic r;
        r = 1'b1;
        if (cp > 24'h10FFFF)                      r = 1'b0;
        if (cp >= 24'h00D800 && cp <= 24'h00DFFF) r = 1'b0;
        if (cp >= 24'h00FDD0 && cp <= 24'h00FDEF) r = 1'b0;
        if (cp[15:1] == 15'h7FFF)                 r = 1'b0;
        return r;
    endfunction

    // Length in the top bits, bytes in emission order below
    function automatic logic [34:0] utf8_enc(input logic [qsu_pkg::CP_W-1:0] cp);
        logic [3:0][7:0] b;
        logic [2:0]      n;
        b = '0;
        if (cp >= 24'h010000) begin
            n    = 3'd4;
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
        end else if (cp >= 24'h000800) begin
            n    = 3'd3;
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
        end else if (cp >= 24'h000080) begin
            n    = 3'd2;
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
        end else begin
            n    = 3'd1;
            b[0] = cp[7:0];
        end
        return {n, b};
    endfunction

    // A byte inside the string body
    function automatic t_body body_byte(input logic [7:0] c);
        t_body r;
        r = '{vld: 1'b0, kind: qsu_pkg::K_BYTE, data: 8'd0, err: 2'd0, mode: M_BODY};
        if (c == 8'h22) begin
            r.vld  = 1'b1;
            r.kind = qsu_pkg::K_END;
            r.mode = M_WAIT;
        end else if (c == 8'h00) begin
            r.vld  = 1'b1;
            r.kind = qsu_pkg::K_ERR;
            r.err  = qsu_pkg::E_UNTERM;
            r.mode = M_WAIT;
        end else if (c == 8'h5C) begin
            r.mode = M_ESC;
        end else begin
            r.vld  = 1'b1;
            r.data = c;
        end
        return r;
    endfunction

    t_mode                   r_mode, n_mode;
    logic [qsu_pkg::CP_W-1:0] r_acc, n_acc;
    logic [CW-1:0]           r_cnt, n_cnt;
    qsu_pkg::t_cmd           cmd;
    logic                    accept;

    logic [4:0]              hv;
    logic [qsu_pkg::CP_W-1:0] acc_sh;
    logic [34:0]             enc;
    t_body                   bb;

    assign o_rdy  = !i_full;
    assign accept = i_vld && o_rdy;

    assign hv     = hex_value(i_data);
    assign acc_sh = {r_acc[qsu_pkg::CP_W-5:0], hv[3:0]};
    assign bb     = body_byte(i_data);

    // Finish on the shifted value when the digit run fills up, else on the held one
    assign enc = utf8_enc((hv[4] && r_cnt == CW'(MAX_HEX_DIGITS - 1)) ? acc_sh : r_acc);

    // Classify the byte against the parse mode
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        cmd    = '0;
        unique case (r_mode)
            M_BODY: begin
                n_mode        = bb.mode;
                cmd.tail_vld  = bb.vld;
                cmd.tail_kind = bb.kind;
                cmd.tail_data = bb.data;
                cmd.tail_err  = bb.err;
            end
            M_ESC: begin
                n_mode       = M_BODY;
                cmd.tail_vld = 1'b1;
                case (i_data)
                    8'h62: cmd.tail_data = 8'h08;
                    8'h74: cmd.tail_data = 8'h09;
                    8'h6E: cmd.tail_data = 8'h0A;
                    8'h72: cmd.tail_data = 8'h0D;
                    8'h5C: cmd.tail_data = 8'h5C;
                    8'h22: cmd.tail_data = 8'h22;
                    8'h75, 8'h55: begin
                        cmd.tail_vld = 1'b0;
                        n_mode       = M_PLUS;
                    end
                    default: begin
                        cmd.tail_kind = qsu_pkg::K_ERR;
                        cmd.tail_err  = qsu_pkg::E_BAD_ESC;
                        n_mode        = M_WAIT;
                    end
                endcase
            end
            M_PLUS: begin
                if (i_data == 8'h2B) begin
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_mode = M_HEX;
                end else begin
                    cmd.tail_vld  = 1'b1;
                    cmd.tail_kind = qsu_pkg::K_ERR;
                    cmd.tail_err  = qsu_pkg::E_BAD_ESC;
                    n_mode        = M_WAIT;
                end
            end
            M_HEX: begin
                if (hv[4] && r_cnt != CW'(MAX_HEX_DIGITS - 1)) begin
                    // Collect one more digit
                    n_acc = acc_sh;
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    // Run ends: check the code point and expand it
                    n_acc = '0;
                    n_cnt = '0;
                    if (!cp_ok(hv[4] ? acc_sh : r_acc)) begin
                        cmd.tail_vld  = 1'b1;
                        cmd.tail_kind = qsu_pkg::K_ERR;
                        cmd.tail_err  = qsu_pkg::E_BAD_CP;
                        n_mode        = M_WAIT;
                    end else begin
                        cmd.cp_len   = enc[34:32];
                        cmd.cp_bytes = enc[31:0];
                        n_mode       = M_BODY;
                        if (!hv[4]) begin
                            // Terminating byte is then a body byte
                            n_mode        = bb.mode;
                            cmd.tail_vld  = bb.vld;
                            cmd.tail_kind = bb.kind;
                            cmd.tail_data = bb.data;
                            cmd.tail_err  = bb.err;
                        end
                    end
                end
            end
            default: begin
                if (i_data == 8'h22) begin
                    n_mode = M_BODY;
                end else begin
                    cmd.tail_vld  = 1'b1;
                    cmd.tail_kind = qsu_pkg::K_ERR;
                    cmd.tail_err  = qsu_pkg::E_NO_QUOTE;
                    n_mode        = M_WAIT;
                end
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.tail_vld || cmd.cp_len != 3'd0);

    // Hold parse state, advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_WAIT;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_HEX |-> r_cnt < CW'(MAX_HEX_DIGITS))
        else $error("hex digit count beyond limit");

endmodule

// ----- design/qsu_fifo.sv -----
module qsu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qsu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_vld,
    output qsu_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    qsu_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_cnt;

    assign o_full = (r_cnt == NW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_cmd  = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_vld |-> !i_pop)
        else $error("pop from empty command queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("command queue count out of range");

endmodule

// ----- design/qsu_back.sv -----
module qsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  qsu_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_vld,
    input  logic          i_rdy,
    output qsu_pkg::t_res o_res
);

    logic [2:0]    r_idx;
    logic          r_out_vld;
    qsu_pkg::t_res r_res;
    qsu_pkg::t_res cur;
    logic [2:0]    total;
    logic          load;

    // Pick the result at the current position in the head command
    assign total = i_cmd.cp_len + {2'b00, i_cmd.tail_vld};

    always_comb begin
        cur.last = (r_idx == total - 3'd1);
        if (r_idx < i_cmd.cp_len) begin
            cur.kind = qsu_pkg::K_BYTE;
            cur.data = i_cmd.cp_bytes[r_idx[1:0]];
            cur.err  = 2'd0;
        end else begin
            cur.kind = i_cmd.tail_kind;
            cur.data = i_cmd.tail_data;
            cur.err  = i_cmd.tail_err;
        end
    end

    assign load  = i_vld && (!r_out_vld || i_rdy);
    assign o_pop = load && cur.last;
    assign o_vld = r_out_vld;
    assign o_res = r_res;

    // Step through results, hold the output beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_idx     <= cur.last ? 3'd0 : r_idx + 3'd1;
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= cur;
        end
    end

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_vld && r_res.last && r_idx == 3'd0))
        else $error("command retired without a final beat");

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> r_idx < total)
        else $error("result position beyond command");

endmodule
